FILE: rtl/flash_program_erase_controller_macros.svh
// Assertion helpers for the flash controller checker.
`ifndef FLASH_PROGRAM_ERASE_CONTROLLER_MACROS_SVH
`define FLASH_PROGRAM_ERASE_CONTROLLER_MACROS_SVH

// Same-cycle implication, off during reset.
`define FPEC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define FPEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle consequence of reset itself.
`define FPEC_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fpec_pkg.sv
`default_nettype none

package fpec_pkg;

   localparam int REG_WORDS_DEF   = 16;
   localparam int FLASH_BYTES_DEF = 262144;
   localparam int EOFF_W          = 18;
   localparam int PROT_BITS       = 32;
   localparam int SECTOR_SHIFT    = 12;

   localparam logic [31:0] FLASH_BASE_RESET = 32'h0800_0000;

   localparam int PAGE_BYTES   = 256;
   localparam int SECTOR_BYTES = 4096;
   localparam int BLOCK_BYTES  = 32768;

   localparam logic [31:0] KEY_FIRST  = 32'h4567_0123;
   localparam logic [31:0] KEY_SECOND = 32'hCDEF_89AB;

   localparam logic [7:0] ST_BUSY      = 8'h01;
   localparam logic [7:0] ST_WBUSY     = 8'h02;
   localparam logic [7:0] ST_PROTERR   = 8'h10;
   localparam logic [7:0] ST_DONE      = 8'h20;
   localparam logic [7:0] ST_CLEARABLE = 8'hB3;

   localparam logic [31:0] CT_SECT     = 32'h0000_0002;
   localparam logic [31:0] CT_MASS     = 32'h0000_0004;
   localparam logic [31:0] CT_OPTPROG  = 32'h0000_0010;
   localparam logic [31:0] CT_OPTERASE = 32'h0000_0020;
   localparam logic [31:0] CT_START    = 32'h0000_0040;
   localparam logic [31:0] CT_LOCK     = 32'h0000_0080;
   localparam logic [31:0] CT_OPTWE    = 32'h0000_0200;
   localparam logic [31:0] CT_FLOCK    = 32'h0000_8000;
   localparam logic [31:0] CT_PAGE     = 32'h0002_0000;
   localparam logic [31:0] CT_BLOCK    = 32'h0004_0000;
   localparam logic [31:0] CT_PSTART   = 32'h0020_0000;

   localparam logic [7:0] OFF_KEY       = 8'h04;
   localparam logic [7:0] OFF_OPTKEY    = 8'h08;
   localparam logic [7:0] OFF_STATUS    = 8'h0C;
   localparam logic [7:0] OFF_CTRL      = 8'h10;
   localparam logic [7:0] OFF_KEY_ALIAS = 8'h24;

   localparam int WORD_CTRL   = 4;
   localparam int WORD_ADDR   = 5;
   localparam int WORD_WRPROT = 8;

   localparam logic       MODE_READ = 1'b0;
   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;

   typedef enum logic [2:0] {
      ERASE_NONE   = 3'd0,
      ERASE_PAGE   = 3'd1,
      ERASE_SECTOR = 3'd2,
      ERASE_BLOCK  = 3'd3,
      ERASE_MASS   = 3'd4
   } erase_kind_type;

   typedef enum logic [1:0] {
      ACC_OK         = 2'd0,
      ACC_BAD_OFFSET = 2'd1,
      ACC_BAD_SIZE   = 2'd2
   } acc_err_type;

   typedef struct packed {
      logic        mode;
      logic [7:0]  offset;
      logic [2:0]  access_size;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0]       read_data;
      logic [2:0]        erase_kind;
      logic [EOFF_W-1:0] erase_offset;
      logic [1:0]        access_error;
   } rsp_type;

   typedef struct packed {
      logic              emit;
      logic              prot_err;
      logic [EOFF_W-1:0] offset;
   } erase_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/fpec_erase.sv
`default_nettype none

module fpec_erase #(
   parameter int FLASH_BYTES = fpec_pkg::FLASH_BYTES_DEF
) (
   input  fpec_pkg::erase_kind_type kind,
   input  logic [31:0]              erase_addr,
   input  logic [31:0]              flash_base,
   input  logic [31:0]              wr_prot,
   output fpec_pkg::erase_cmd_type  cmd
);
   import fpec_pkg::*;

   localparam int OW = $clog2(FLASH_BYTES) + 2;
   localparam int SW = OW - SECTOR_SHIFT;
   localparam logic [OW-1:0] FLASH_END = OW'(FLASH_BYTES);
   localparam logic [SW-1:0] SECT_CAP  = SW'(PROT_BITS - 1);
   localparam logic [4:0]    SECT_TOP  = 5'(PROT_BITS - 1);

   logic [32:0]   diff;
   logic          in_range;
   logic [OW-1:0] rel;
   logic [OW-1:0] size;
   logic [OW-1:0] start_off;
   logic [OW-1:0] end_off;
   logic [OW-1:0] stop_off;
   logic [OW-1:0] last_byte;
   logic          past_end;
   logic [SW-1:0] first_sect;
   logic [SW-1:0] last_sect;
   logic [4:0]    first_c;
   logic [4:0]    last_c;
   logic [31:0]   covered;
   logic          prot;

   always_comb begin
      diff     = {1'b0, erase_addr} - {1'b0, flash_base};
      in_range = !diff[32] && (diff[31:0] < 32'(FLASH_BYTES));
      rel      = diff[OW-1:0];

      unique case (kind)
         ERASE_PAGE:   size = OW'(PAGE_BYTES);
         ERASE_SECTOR: size = OW'(SECTOR_BYTES);
         ERASE_BLOCK:  size = OW'(BLOCK_BYTES);
         ERASE_MASS:   size = FLASH_END;
         default:      size = '0;
      endcase

      start_off  = (kind == ERASE_MASS) ? '0 : (rel & ~(size - OW'(1)));
      end_off    = start_off + size;
      past_end   = end_off > FLASH_END;
      stop_off   = past_end ? FLASH_END : end_off;
      last_byte  = stop_off - OW'(1);
      first_sect = start_off[OW-1:SECTOR_SHIFT];
      last_sect  = last_byte[OW-1:SECTOR_SHIFT];
      first_c    = (first_sect > SECT_CAP) ? SECT_TOP : first_sect[4:0];
      last_c     = (last_sect > SECT_CAP) ? SECT_TOP : last_sect[4:0];

      for (int j = 0; j < PROT_BITS; j++) begin
         covered[j] = (5'(j) >= first_c) && (5'(j) <= last_c);
      end
      prot = |(covered & wr_prot);

      cmd = '0;
      unique case (kind)
         ERASE_NONE: begin
            cmd = '0;
         end
         ERASE_MASS: begin
            cmd.prot_err = prot;
            cmd.emit     = !prot;
         end
         ERASE_BLOCK: begin
            if (in_range) begin
               cmd.prot_err = prot;
               cmd.emit     = !prot;
            end
         end
         ERASE_SECTOR, ERASE_PAGE: begin
            if (in_range && !past_end) begin
               cmd.prot_err = prot;
               cmd.emit     = !prot;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase

      if (cmd.emit && (kind != ERASE_MASS)) begin
         cmd.offset = EOFF_W'(start_off);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/fpec_regs.sv
`default_nettype none

module fpec_regs #(
   parameter int REG_WORDS   = fpec_pkg::REG_WORDS_DEF,
   parameter int FLASH_BYTES = fpec_pkg::FLASH_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              execute,
   input  fpec_pkg::req_type item,
   input  logic              csr_write,
   input  logic [31:0]       csr_wdata,
   output fpec_pkg::rsp_type result
);
   import fpec_pkg::*;

   localparam int         IW        = $clog2(REG_WORDS);
   localparam logic [8:0] WIN_BYTES = 9'(REG_WORDS * 4);

   logic [31:0]    words_ff [REG_WORDS];
   logic [31:0]    words_in [REG_WORDS];
   logic [7:0]     status_ff;
   logic [7:0]     status_in;
   logic [7:0]     status_pre;
   logic           unlocked_ff;
   logic           unlocked_in;
   logic           key_stage_ff;
   logic           key_stage_in;
   logic           opt_stage_ff;
   logic           opt_stage_in;
   logic [31:0]    base_ff;

   logic [IW-1:0]  idx;
   logic           bad_off;
   logic           size_ok;
   logic [31:0]    word_rd;
   logic [31:0]    rd_val;
   logic [31:0]    ctrl_nw;
   logic           ctrl_unl;
   logic           finish;
   erase_kind_type erase_req;
   erase_cmd_type  ecmd;
   acc_err_type    err;

   fpec_erase #(
      .FLASH_BYTES(FLASH_BYTES)
   ) u_erase (
      .kind      (erase_req),
      .erase_addr(words_ff[WORD_ADDR]),
      .flash_base(base_ff),
      .wr_prot   (words_ff[WORD_WRPROT]),
      .cmd       (ecmd)
   );

   always_comb begin
      idx     = item.offset[IW+1:2];
      bad_off = {1'b0, item.offset} >= WIN_BYTES;
      size_ok = (item.access_size == SIZE_BYTE) || (item.access_size == SIZE_HALF) ||
                (item.access_size == SIZE_WORD);

      if (item.offset == OFF_KEY) begin
         word_rd = '0;
      end else if (item.offset == OFF_STATUS) begin
         word_rd = {24'b0, status_ff};
      end else begin
         word_rd = words_ff[idx] >> {item.offset[1:0], 3'b000};
      end

      words_in     = words_ff;
      status_pre   = status_ff;
      unlocked_in  = unlocked_ff;
      key_stage_in = key_stage_ff;
      opt_stage_in = opt_stage_ff;
      ctrl_nw      = item.write_data;
      ctrl_unl     = unlocked_ff;
      erase_req    = ERASE_NONE;
      finish       = 1'b0;
      rd_val       = '0;
      err          = ACC_OK;

      priority if (bad_off) begin
         err = ACC_BAD_OFFSET;
      end else if (item.mode == MODE_READ) begin
         if (!size_ok) begin
            err = ACC_BAD_SIZE;
         end else begin
            unique case (item.access_size)
               SIZE_BYTE: rd_val = word_rd & 32'h0000_00FF;
               SIZE_HALF: rd_val = word_rd & 32'h0000_FFFF;
               default:   rd_val = word_rd;
            endcase
         end
      end else if (item.offset[1:0] != 2'b00) begin
         err = ACC_BAD_OFFSET;
      end else if (item.access_size != SIZE_WORD) begin
         err = ACC_BAD_SIZE;
      end else if ((item.offset == OFF_KEY) || (item.offset == OFF_KEY_ALIAS)) begin
         if (item.write_data == KEY_FIRST) begin
            key_stage_in = 1'b1;
         end else begin
            if (key_stage_ff && (item.write_data == KEY_SECOND)) begin
               unlocked_in          = 1'b1;
               words_in[WORD_CTRL] = words_ff[WORD_CTRL] & ~(CT_LOCK | CT_FLOCK);
            end
            key_stage_in = 1'b0;
         end
      end else if (item.offset == OFF_OPTKEY) begin
         if (item.write_data == KEY_FIRST) begin
            opt_stage_in = 1'b1;
         end else begin
            if (opt_stage_ff && (item.write_data == KEY_SECOND)) begin
               words_in[WORD_CTRL] = words_ff[WORD_CTRL] | CT_OPTWE;
            end
            opt_stage_in = 1'b0;
         end
      end else if (item.offset == OFF_STATUS) begin
         status_pre = status_ff & ~(item.write_data[7:0] & ST_CLEARABLE);
      end else if (item.offset == OFF_CTRL) begin
         if ((ctrl_nw & CT_LOCK) != '0) begin
            ctrl_unl = 1'b0;
            ctrl_nw  = ctrl_nw & ~CT_OPTWE;
         end
         if (ctrl_unl && ((ctrl_nw & CT_START) != '0)) begin
            priority if ((ctrl_nw & CT_MASS) != '0) begin
               erase_req = ERASE_MASS;
               ctrl_nw   = ctrl_nw & ~(CT_START | CT_MASS);
            end else if ((ctrl_nw & CT_OPTERASE) != '0) begin
               finish  = 1'b1;
               ctrl_nw = ctrl_nw & ~(CT_START | CT_OPTERASE);
            end else if ((ctrl_nw & CT_BLOCK) != '0) begin
               erase_req = ERASE_BLOCK;
               ctrl_nw   = ctrl_nw & ~(CT_START | CT_BLOCK);
            end else if ((ctrl_nw & CT_SECT) != '0) begin
               erase_req = ERASE_SECTOR;
               ctrl_nw   = ctrl_nw & ~(CT_START | CT_SECT);
            end else if ((ctrl_nw & CT_PAGE) != '0) begin
               erase_req = ERASE_PAGE;
               ctrl_nw   = ctrl_nw & ~(CT_START | CT_PAGE);
            end else if ((ctrl_nw & CT_OPTPROG) != '0) begin
               finish  = 1'b1;
               ctrl_nw = ctrl_nw & ~(CT_START | CT_OPTPROG);
            end else begin
               finish  = 1'b1;
               ctrl_nw = ctrl_nw & ~CT_START;
            end
         end
         if ((ctrl_nw & CT_PSTART) != '0) begin
            finish  = 1'b1;
            ctrl_nw = ctrl_nw & ~CT_PSTART;
         end
         unlocked_in         = ctrl_unl;
         words_in[WORD_CTRL] = ctrl_nw;
      end else begin
         words_in[idx] = item.write_data;
      end
   end

   always_comb begin
      status_in = status_pre;
      if (finish || (erase_req != ERASE_NONE)) begin
         status_in = (status_pre & ~(ST_BUSY | ST_WBUSY)) | ST_DONE;
         if (ecmd.prot_err) begin
            status_in = status_in | ST_PROTERR;
         end
      end
   end

   always_comb begin
      result.read_data    = rd_val;
      result.erase_kind   = ecmd.emit ? erase_req : ERASE_NONE;
      result.erase_offset = ecmd.offset;
      result.access_error = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_WORDS; i++) begin
            words_ff[i] <= '0;
         end
         status_ff    <= '0;
         unlocked_ff  <= 1'b0;
         key_stage_ff <= 1'b0;
         opt_stage_ff <= 1'b0;
      end else if (execute) begin
         words_ff     <= words_in;
         status_ff    <= status_in;
         unlocked_ff  <= unlocked_in;
         key_stage_ff <= key_stage_in;
         opt_stage_ff <= opt_stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= FLASH_BASE_RESET;
      end else if (csr_write) begin
         base_ff <= csr_wdata;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/flash_program_erase_controller.sv
// An accepted item loads the input register, then its result loads the result register.
// Throughput: one item per cycle unless the result is stalled; register decode, key
// check and the erase/protection test sit between the input and result registers.
// Reset (synchronous, active high) empties both registers, relocks, clears key
// stages, status and all register words, and sets the flash base to 0x08000000.
`default_nettype none

module flash_program_erase_controller #(
   parameter int REG_WORDS   = fpec_pkg::REG_WORDS_DEF,
   parameter int FLASH_BYTES = fpec_pkg::FLASH_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fpec_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpec_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [31:0]       csr_wdata
);
   import fpec_pkg::*;

   logic    in_vld_ff;
   logic    in_vld_in;
   req_type in_data_ff;
   logic    rsp_vld_ff;
   logic    rsp_vld_in;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    advance;
   logic    take;

   fpec_regs #(
      .REG_WORDS  (REG_WORDS),
      .FLASH_BYTES(FLASH_BYTES)
   ) u_regs (
      .clock    (clock),
      .reset    (reset),
      .execute  (advance),
      .item     (in_data_ff),
      .csr_write(csr_write),
      .csr_wdata(csr_wdata),
      .result   (result)
   );

   always_comb begin
      advance    = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
      req_stall  = in_vld_ff && !advance;
      take       = req_valid && !req_stall;
      in_vld_in  = take || (in_vld_ff && !advance);
      rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);
      rsp_valid  = rsp_vld_ff;
      rsp_data   = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/fpec_checker.sv
`default_nettype none

`include "flash_program_erase_controller_macros.svh"

module fpec_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire fpec_pkg::rsp_type rsp_data
);
   import fpec_pkg::*;

   `FPEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled item changed or dropped")
   `FPEC_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_valid && !req_stall, "pipeline not empty after reset")
   `FPEC_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a blocked result")
   `FPEC_ASSERT_IMPLY(a_err_quiet, clock, reset, rsp_valid && (rsp_data.access_error != ACC_OK), (rsp_data.read_data == '0) && (rsp_data.erase_kind == ERASE_NONE), "failed access returned data or erase")

endmodule

bind flash_program_erase_controller fpec_checker u_checker (.*);

`default_nettype wire
